### sv/ptlru_pkg.sv
// ----------------------------------------------------------------------------
// ptlru_pkg: shared constants for the page translation block
// Field widths, table geometry and the free-frame reload rule used when the
// frame count register is reset or written.
// ----------------------------------------------------------------------------
package ptlru_pkg;

  localparam int ADDR_W      = 12;
  localparam int OFFSET_BITS = 7;
  localparam int PAGE_W      = ADDR_W - OFFSET_BITS;
  localparam int PAGE_COUNT  = 1 << PAGE_W;
  localparam int FRAME_W     = 5;
  localparam int STAMP_W     = 32;
  localparam int CFG_W       = 6;
  localparam int SCAN_W      = PAGE_W + 1;

  localparam logic [CFG_W-1:0] FRAMES_MIN   = CFG_W'(2);
  localparam logic [CFG_W-1:0] FRAMES_MAX   = CFG_W'(32);
  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(8);

  typedef logic [FRAME_W-1:0] frame_t;

  // Number of frames free for hand-out: the clamped frame count less the
  // reserved frame zero.
  function automatic frame_t free_reload(input logic [CFG_W-1:0] count);
    logic [CFG_W-1:0] eff;
    logic [CFG_W-1:0] left;
    if (count < FRAMES_MIN) begin
      eff = FRAMES_MIN;
    end else if (count > FRAMES_MAX) begin
      eff = FRAMES_MAX;
    end else begin
      eff = count;
    end
    left = eff - CFG_W'(1);
    return left[FRAME_W-1:0];
  endfunction

endpackage

### sv/page_translate_lru.sv
// ----------------------------------------------------------------------------
// page_translate_lru: demand-paging address translation with LRU replacement
// Translates a virtual address through a resident page table, hands out free
// frames on a fault and evicts the least recently stamped page once none
// remain.
// ----------------------------------------------------------------------------
// Usage.
// A transfer is taken at a rising edge where start is high and busy is low;
// virtual_address carries the page number in its upper bits and the byte
// offset in its lower seven bits. Each transfer produces exactly one result:
// physical_address and page_fault are shown for a single cycle, marked by
// done. The receiver cannot hold a result off, so it must sample on done.
// A hit, or a fault served from the free pool, passes through the lookup
// state only, so busy is high for one cycle only and done is registered as
// that state ends. A fault with no free frame left runs the shared stamp
// comparator over all 32 table entries, one stamp read from the stamp RAM
// per cycle, then reads the victim's frame; busy stays high through lookup,
// scan, victim and finish, and done is registered as finish ends. Those 32
// compares through the single stamp read port set the worst rate.
// The frame count register is written through cfg_write and cfg_data while
// the block is idle; a write reloads the free-frame count and keeps the table.
// Reset (rst, synchronous) clears every valid bit, the access counter and the
// outputs, and loads the free count for the default of eight frames. The
// frame and stamp RAMs are not cleared; an entry is only read once written.
// ----------------------------------------------------------------------------
module page_translate_lru (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [ptlru_pkg::ADDR_W-1:0]     virtual_address,
  output logic                             done,
  output logic [ptlru_pkg::ADDR_W-1:0]     physical_address,
  output logic                             page_fault,
  input  logic                             cfg_write,
  input  logic [ptlru_pkg::CFG_W-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_VICTIM,
    ST_FINISH
  } state_t;

  localparam int PW = ptlru_pkg::PAGE_W;
  localparam int FW = ptlru_pkg::FRAME_W;
  localparam int SW = ptlru_pkg::STAMP_W;
  localparam int OW = ptlru_pkg::OFFSET_BITS;
  localparam int CW = ptlru_pkg::SCAN_W;
  localparam int NP = ptlru_pkg::PAGE_COUNT;

  state_t           state;
  logic [NP-1:0]    entry_valid;
  logic [SW-1:0]    access_counter;
  logic [FW-1:0]    free_left;
  logic [PW-1:0]    page_q;
  logic [OW-1:0]    offset_q;
  logic [CW-1:0]    scan_cnt;
  logic             found;
  logic [SW-1:0]    best;
  logic [PW-1:0]    victim;

  // The frame and stamp tables are RAMs with one registered read port each.
  logic [FW-1:0]    frame_mem [NP];
  logic [SW-1:0]    stamp_mem [NP];
  logic [FW-1:0]    frame_q;
  logic [SW-1:0]    stamp_q;

  logic             accept;
  logic             hit;
  logic             from_pool;
  logic [PW-1:0]    frame_rd_addr;
  logic             frame_we;
  logic             stamp_we;
  logic [FW-1:0]    frame_wdata;
  logic [PW-1:0]    cmp_idx;
  logic             cmp_take;
  logic [FW-1:0]    finish_frame;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign hit       = entry_valid[page_q];
  assign from_pool = (free_left != '0);

  // Read address: the requested page, but the chosen victim in the victim state.
  assign frame_rd_addr = (state == ST_VICTIM) ? victim : virtual_address[ptlru_pkg::ADDR_W-1:OW];

  assign finish_frame = found ? frame_q : '0;
  assign frame_wdata  = (state == ST_FINISH) ? finish_frame : free_left;
  assign frame_we     = ((state == ST_LOOKUP) && !hit && from_pool) || (state == ST_FINISH);
  assign stamp_we     = ((state == ST_LOOKUP) && (hit || from_pool)) || (state == ST_FINISH);

  // The stamp read issued last cycle belongs to the entry one below the count.
  assign cmp_idx  = scan_cnt[PW-1:0] - PW'(1);
  assign cmp_take = (scan_cnt != '0) && entry_valid[cmp_idx] && (cmp_idx != page_q) &&
                    (!found || (stamp_q < best));

  always_ff @(posedge clk) begin
    frame_q <= frame_mem[frame_rd_addr];
    if (frame_we) begin
      frame_mem[page_q] <= frame_wdata;
    end
  end

  always_ff @(posedge clk) begin
    stamp_q <= stamp_mem[scan_cnt[PW-1:0]];
    if (stamp_we) begin
      stamp_mem[page_q] <= access_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      entry_valid    <= '0;
      access_counter <= '0;
      free_left      <= ptlru_pkg::free_reload(ptlru_pkg::FRAMES_RESET);
      done           <= 1'b0;
      page_fault     <= 1'b0;
      physical_address <= '0;
      scan_cnt       <= '0;
      found          <= 1'b0;
      best           <= '0;
      victim         <= '0;
      page_q         <= '0;
      offset_q       <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            page_q   <= virtual_address[ptlru_pkg::ADDR_W-1:OW];
            offset_q <= virtual_address[OW-1:0];
            state    <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (hit || from_pool) begin
            // Resident page, or a fault served from the free pool.
            done             <= 1'b1;
            page_fault       <= !hit;
            physical_address <= {(hit ? frame_q : free_left), offset_q};
            access_counter   <= access_counter + SW'(1);
            if (!hit) begin
              entry_valid[page_q] <= 1'b1;
              free_left           <= free_left - FW'(1);
            end
            state <= ST_IDLE;
          end else begin
            scan_cnt <= '0;
            found    <= 1'b0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cmp_take) begin
            found  <= 1'b1;
            best   <= stamp_q;
            victim <= cmp_idx;
          end
          if (scan_cnt == CW'(NP)) begin
            state <= ST_VICTIM;
          end else begin
            scan_cnt <= scan_cnt + CW'(1);
          end
        end
        ST_VICTIM: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (found) begin
            entry_valid[victim] <= 1'b0;
          end
          entry_valid[page_q] <= 1'b1;
          done             <= 1'b1;
          page_fault       <= 1'b1;
          physical_address <= {finish_frame, offset_q};
          access_counter   <= access_counter + SW'(1);
          state            <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // User keeps configuration to idle (not enforced); it reloads the free pool.
      if (cfg_write) begin
        free_left <= ptlru_pkg::free_reload(cfg_data);
      end
    end
  end

  // A result is only ever produced by a transfer that was in progress.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a transfer in progress");

  // Accepting a transfer always leaves the block busy for the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("block not busy after accepting a transfer");

  // The eviction scan only runs once the free pool is exhausted.
  a_scan_pool_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (free_left == '0))
    else $error("scan started with free frames left");

  // A chosen victim is resident and never the faulting page itself.
  a_victim_legal: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FINISH) && found) |-> (entry_valid[victim] && (victim != page_q)))
    else $error("illegal eviction victim");

  // A hit or a fault served from the pool raises its strobe straight after lookup.
  a_hit_latency: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_LOOKUP) && (hit || from_pool)) |=> done)
    else $error("hit or pool fault did not complete in one cycle");

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the page translation block
// Feeds virtual addresses through the command handshake, predicts each
// translation from a private copy of the page table and checks every result
// field against it, across several settings of the frame count register.
// ----------------------------------------------------------------------------
module tb;

  localparam int ADDR_W      = ptlru_pkg::ADDR_W;
  localparam int OFFSET_BITS = ptlru_pkg::OFFSET_BITS;
  localparam int PAGE_W      = ptlru_pkg::PAGE_W;
  localparam int PAGE_COUNT  = ptlru_pkg::PAGE_COUNT;
  localparam int STAMP_W     = ptlru_pkg::STAMP_W;
  localparam int CFG_W       = ptlru_pkg::CFG_W;

  // The slowest transfer is an eviction, plus the drawn idle gap before the
  // next start. Anything far beyond that is a hang.
  localparam int STALL_LIMIT  = 1000;
  localparam int PHASE_ITEMS  = 130;
  localparam int DRAIN_CYCLES = 40;

  typedef logic [ADDR_W-1:0]  vaddr_t;
  typedef logic [STAMP_W-1:0] stamp_t;

  // One translation as the block should report it.
  typedef struct packed {
    vaddr_t paddr;
    logic   fault;
  } xlate_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  vaddr_t               virtual_address = '0;
  logic                 done;
  vaddr_t               physical_address;
  logic                 page_fault;
  logic                 cfg_write = 1'b0;
  logic [CFG_W-1:0]     cfg_data = '0;

  page_translate_lru dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .virtual_address  (virtual_address),
    .done             (done),
    .physical_address (physical_address),
    .page_fault       (page_fault),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Addresses waiting to be offered, and translations waiting to come back.
  vaddr_t va_backlog[$];
  xlate_t xlate_due[$];

  int     fails = 0;
  int     gap_left = 0;
  bit     no_gaps = 1'b0;
  int     stall_count = 0;
  xlate_t want;

  // ---------------------------------------------------------------------------
  // Shadow page table. It follows every accepted transfer and every write of
  // the frame count register, so it always mirrors what the block should hold.
  // ---------------------------------------------------------------------------
  bit                  pt_valid [PAGE_COUNT];
  ptlru_pkg::frame_t   pt_frame [PAGE_COUNT];
  stamp_t              pt_stamp [PAGE_COUNT];
  stamp_t              use_count;
  ptlru_pkg::frame_t   free_frames;
  logic [CFG_W-1:0]    frames_reg;

  // Frames available for hand-out under a given register value. Values below
  // two behave as two and values above 32 as 32; frame zero is held back.
  function automatic ptlru_pkg::frame_t frames_free(input logic [CFG_W-1:0] count);
    int eff;
    eff = (count < 2) ? 2 : (count > 32) ? 32 : int'(count);
    return ptlru_pkg::frame_t'(eff - 1);
  endfunction

  // Translates one address and updates the shadow table exactly as the block
  // is meant to: hit, fault served from the free pool, or fault with eviction
  // of the valid page holding the smallest stamp (lowest page on a tie).
  function automatic xlate_t translate_va(input vaddr_t va);
    int                page;
    int                victim;
    ptlru_pkg::frame_t frame;
    xlate_t            res;
    page   = int'(va[ADDR_W-1:OFFSET_BITS]);
    victim = -1;
    res.fault = 1'b0;
    if (pt_valid[page]) begin
      frame = pt_frame[page];
    end else begin
      res.fault = 1'b1;
      if (free_frames != 0) begin
        frame = free_frames;
        free_frames = free_frames - 1'b1;
      end else begin
        for (int i = 0; i < PAGE_COUNT; i++) begin
          if (i != page && pt_valid[i]) begin
            if (victim < 0 || pt_stamp[i] < pt_stamp[victim]) begin
              victim = i;
            end
          end
        end
        if (victim >= 0) begin
          frame = pt_frame[victim];
          pt_valid[victim] = 1'b0;
        end else begin
          // Nothing else resident: the page falls back to the reserved frame.
          frame = '0;
        end
      end
      pt_valid[page] = 1'b1;
      pt_frame[page] = frame;
    end
    pt_stamp[page] = use_count;
    use_count = use_count + 1'b1;
    res.paddr = {frame, va[OFFSET_BITS-1:0]};
    return res;
  endfunction

  function automatic vaddr_t make_va(input int page, input int offset);
    return {PAGE_W'(page), OFFSET_BITS'(offset)};
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. An address is offered with start and held until the edge at which
  // busy is low; the expected translation is worked out at that very edge.
  // Each address carries a drawn number of idle cycles that follows its
  // transfer, unless the phase runs back to back.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        xlate_due.push_back(translate_va(virtual_address));
      end
      if (start && busy) begin
        // The offer stands until the block takes it.
      end else if (gap_left != 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (va_backlog.size() != 0) begin
        start           <= 1'b1;
        virtual_address <= va_backlog.pop_front();
        gap_left        <= no_gaps ? 0 : $urandom_range(0, 4);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. A result lives for a single cycle under done, so it is taken at
  // the edge that closes that cycle and matched against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done) begin
      if (xlate_due.size() == 0) begin
        $error("result with nothing expected: physical_address %h page_fault %b",
               physical_address, page_fault);
        fails++;
      end else begin
        want = xlate_due.pop_front();
        if (physical_address !== want.paddr) begin
          $error("physical_address: expected %h, got %h", want.paddr, physical_address);
          fails++;
        end
        if (page_fault !== want.fault) begin
          $error("page_fault: expected %b, got %b", want.fault, page_fault);
          fails++;
        end
      end
    end
  end

  // Watchdog: any transfer in either direction restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_count <= 0;
    end else if (stall_count == STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // Blocks until every queued address has been taken and every translation
  // has come back, which leaves the block idle.
  task automatic wait_idle();
    while (va_backlog.size() != 0 || start || xlate_due.size() != 0 || busy) begin
      @(posedge clk);
    end
  endtask

  // Writes the frame count register while idle; the shadow table is kept and
  // only the free pool is reloaded, as in the block.
  task automatic write_frames(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_write   <= 1'b1;
    cfg_data    <= value;
    frames_reg  = value;
    free_frames = frames_free(value);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Random traffic. Most addresses fall in a working set a little larger than
  // the frame pool, so hits, free-pool faults and evictions all keep turning
  // up; the rest are fully random addresses that exercise every bit.
  task automatic queue_random(input int count);
    int ws;
    int base;
    ws      = int'(frames_free(frames_reg)) + 1 + $urandom_range(0, 3);
    ws      = (ws > PAGE_COUNT) ? PAGE_COUNT : ws;
    base    = $urandom_range(0, PAGE_COUNT - 1);
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 7) begin
        va_backlog.push_back(make_va((base + $urandom_range(0, ws - 1)) % PAGE_COUNT,
                                     $urandom_range(0, 127)));
      end else begin
        va_backlog.push_back(vaddr_t'($urandom_range(0, 4095)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] frame_settings[$];

  initial begin
    for (int i = 0; i < PAGE_COUNT; i++) begin
      pt_valid[i] = 1'b0;
      pt_frame[i] = '0;
      pt_stamp[i] = '0;
    end
    use_count   = '0;
    frames_reg  = ptlru_pkg::FRAMES_RESET;
    free_frames = frames_free(ptlru_pkg::FRAMES_RESET);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed opening under the reset setting of eight frames: the lowest and
    // highest addresses, hits with the extreme offsets, the free pool drained
    // down to frame one, then evictions once it is empty, including the
    // re-fault of a page that has just been evicted.
    va_backlog.push_back(make_va(0, 0));
    va_backlog.push_back(make_va(31, 127));
    va_backlog.push_back(make_va(0, 127));
    va_backlog.push_back(make_va(31, 0));
    va_backlog.push_back(make_va(21, 'h55));
    va_backlog.push_back(make_va(10, 'h2a));
    va_backlog.push_back(make_va(1, 'h01));
    va_backlog.push_back(make_va(2, 'h40));
    va_backlog.push_back(make_va(3, 'h3f));
    va_backlog.push_back(make_va(4, 'h7e));
    va_backlog.push_back(make_va(0, 'h11));
    va_backlog.push_back(make_va(5, 'h22));
    va_backlog.push_back(make_va(31, 'h33));
    va_backlog.push_back(make_va(6, 'h44));
    va_backlog.push_back(make_va(21, 'h66));
    va_backlog.push_back(make_va(10, 'h77));
    va_backlog.push_back(make_va(16, 'h00));
    va_backlog.push_back(make_va(1, 'h7f));
    wait_idle();

    queue_random(PHASE_ITEMS);
    wait_idle();

    // Register settings: below the floor, above the ceiling, both bounds, the
    // nearest out-of-range values, a spread of legal values and the default.
    frame_settings = '{6'd0, 6'd63, 6'd2, 6'd32, 6'd1, 6'd33};
    for (int k = 0; k < 4; k++) begin
      frame_settings.push_back(CFG_W'($urandom_range(2, 32)));
    end
    frame_settings.push_back(ptlru_pkg::FRAMES_RESET);

    foreach (frame_settings[k]) begin
      write_frames(frame_settings[k]);
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    // Leave room for any stray result to show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
